FILE: rtl/multi_position_button_channel_assert.svh
// assertion macros for the multi-position button channel checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef MULTI_POSITION_BUTTON_CHANNEL_ASSERT_SVH
`define MULTI_POSITION_BUTTON_CHANNEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MPBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MPBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mpbc_pkg.sv
// shared types and constants of the multi-position button channel
// no dependencies
`default_nettype none

package mpbc_pkg;

    localparam int MAX_POSITIONS = 16;
    localparam int VALUE_WIDTH   = 12;
    localparam int POS_WIDTH     = 4;
    localparam int COUNT_WIDTH   = 5;
    localparam int WINDOW_WIDTH  = 16;
    localparam int TIME_WIDTH    = 32;
    localparam int ADDR_WIDTH    = 5;
    localparam int DATA_WIDTH    = 32;
    localparam int IDX_WIDTH     = 3;
    localparam int PROD_WIDTH    = VALUE_WIDTH + POS_WIDTH;
    localparam int DIV_STEPS     = PROD_WIDTH;
    localparam int STEP_WIDTH    = $clog2(DIV_STEPS);

    localparam logic [COUNT_WIDTH-1:0]  RST_POSITION_COUNT = COUNT_WIDTH'(0);
    localparam logic [WINDOW_WIDTH-1:0] RST_DOUBLE_PRESS   = WINDOW_WIDTH'(300);
    localparam logic [VALUE_WIDTH-1:0]  RST_CHANNEL_MIN    = VALUE_WIDTH'(1000);
    localparam logic [VALUE_WIDTH-1:0]  RST_CHANNEL_MID    = VALUE_WIDTH'(1500);
    localparam logic [VALUE_WIDTH-1:0]  RST_CHANNEL_MAX    = VALUE_WIDTH'(2000);

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_POSITION_COUNT = 3'd0,
        REG_DOUBLE_PRESS   = 3'd1,
        REG_CHANNEL_MIN    = 3'd2,
        REG_CHANNEL_MID    = 3'd3,
        REG_CHANNEL_MAX    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req;

    typedef struct packed {
        logic                  req_type;
        logic                  pressed;
        logic [TIME_WIDTH-1:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [POS_WIDTH-1:0]   position;
        logic [VALUE_WIDTH-1:0] channel_value;
    } t_out;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  position_count;
        logic [WINDOW_WIDTH-1:0] double_press_ms;
        logic [VALUE_WIDTH-1:0]  channel_min;
        logic [VALUE_WIDTH-1:0]  channel_mid;
        logic [VALUE_WIDTH-1:0]  channel_max;
        logic                    pos_clear;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic map;
        logic div_step;
        logic div_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic direct;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/mpbc_regs.sv
// configuration register file behind the apb-style port
// depends on mpbc_pkg
`default_nettype none

module mpbc_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [mpbc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [mpbc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                                 pready,
    output mpbc_pkg::t_cfg                       o_cfg
);

    logic [mpbc_pkg::COUNT_WIDTH-1:0]  r_position_count;
    logic [mpbc_pkg::WINDOW_WIDTH-1:0] r_double_press;
    logic [mpbc_pkg::VALUE_WIDTH-1:0]  r_channel_min;
    logic [mpbc_pkg::VALUE_WIDTH-1:0]  r_channel_mid;
    logic [mpbc_pkg::VALUE_WIDTH-1:0]  r_channel_max;
    logic                              wr_en;
    mpbc_pkg::t_reg_idx                idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = mpbc_pkg::t_reg_idx'(paddr[mpbc_pkg::ADDR_WIDTH-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_count <= mpbc_pkg::RST_POSITION_COUNT;
            r_double_press   <= mpbc_pkg::RST_DOUBLE_PRESS;
            r_channel_min    <= mpbc_pkg::RST_CHANNEL_MIN;
            r_channel_mid    <= mpbc_pkg::RST_CHANNEL_MID;
            r_channel_max    <= mpbc_pkg::RST_CHANNEL_MAX;
        end else if (wr_en) begin
            case (idx)
                mpbc_pkg::REG_POSITION_COUNT: begin
                    r_position_count <= pwdata[mpbc_pkg::COUNT_WIDTH-1:0];
                end
                mpbc_pkg::REG_DOUBLE_PRESS: begin
                    r_double_press <= pwdata[mpbc_pkg::WINDOW_WIDTH-1:0];
                end
                mpbc_pkg::REG_CHANNEL_MIN: begin
                    r_channel_min <= pwdata[mpbc_pkg::VALUE_WIDTH-1:0];
                end
                mpbc_pkg::REG_CHANNEL_MID: begin
                    r_channel_mid <= pwdata[mpbc_pkg::VALUE_WIDTH-1:0];
                end
                mpbc_pkg::REG_CHANNEL_MAX: begin
                    r_channel_max <= pwdata[mpbc_pkg::VALUE_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            mpbc_pkg::REG_POSITION_COUNT: prdata = mpbc_pkg::DATA_WIDTH'(r_position_count);
            mpbc_pkg::REG_DOUBLE_PRESS:   prdata = mpbc_pkg::DATA_WIDTH'(r_double_press);
            mpbc_pkg::REG_CHANNEL_MIN:    prdata = mpbc_pkg::DATA_WIDTH'(r_channel_min);
            mpbc_pkg::REG_CHANNEL_MID:    prdata = mpbc_pkg::DATA_WIDTH'(r_channel_mid);
            mpbc_pkg::REG_CHANNEL_MAX:    prdata = mpbc_pkg::DATA_WIDTH'(r_channel_max);
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.position_count  = r_position_count;
        o_cfg.double_press_ms = r_double_press;
        o_cfg.channel_min     = r_channel_min;
        o_cfg.channel_mid     = r_channel_mid;
        o_cfg.channel_max     = r_channel_max;
        o_cfg.pos_clear       = wr_en && (idx == mpbc_pkg::REG_POSITION_COUNT);
    end

endmodule

`default_nettype wire

FILE: rtl/mpbc_ctrl.sv
// control state machine: sequences position update, value mapping,
// the iterative divide and the output register handshake; depends on mpbc_pkg
`default_nettype none

module mpbc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  mpbc_pkg::t_status    i_status,
    output mpbc_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAP  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                             r_state, n_state;
    logic [mpbc_pkg::STEP_WIDTH-1:0]    r_step, n_step;
    logic                               r_out_valid, n_out_valid;
    logic                               out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_step    = '0;
                n_state   = i_status.direct ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == mpbc_pkg::STEP_WIDTH'(mpbc_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.div_finish = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mpbc_dp.sv
// datapath: button state, position update, channel mapping, restoring
// divider and output payload register; depends on mpbc_pkg
`default_nettype none

module mpbc_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  mpbc_pkg::t_in        i_in_data,
    input  mpbc_pkg::t_cfg       i_cfg,
    input  mpbc_pkg::t_cmd       i_cmd,
    output mpbc_pkg::t_status    o_status,
    output mpbc_pkg::t_out       o_out_data
);

    localparam int PW = mpbc_pkg::POS_WIDTH;
    localparam int VW = mpbc_pkg::VALUE_WIDTH;
    localparam int CW = mpbc_pkg::COUNT_WIDTH;
    localparam int TW = mpbc_pkg::TIME_WIDTH;
    localparam int QW = mpbc_pkg::PROD_WIDTH;

    logic [PW-1:0]  r_pos, n_pos;
    logic           r_prev, n_prev;
    logic [TW-1:0]  r_last, n_last;
    logic [VW-1:0]  r_value;
    logic           r_neg;
    logic [PW-1:0]  r_div;
    logic [QW-1:0]  r_quo;
    logic [PW-1:0]  r_rem;
    mpbc_pkg::t_out r_out;

    logic           momentary;
    logic [CW-1:0]  count;
    logic [CW-1:0]  pos_inc;
    logic [TW-1:0]  elapsed;
    logic           rising;
    logic           direct;
    logic [VW-1:0]  direct_value;
    logic [VW:0]    span;
    logic [VW-1:0]  mag;
    logic [QW-1:0]  prod;
    logic [PW:0]    trial;
    logic           q_bit;
    logic [PW-1:0]  rem_next;

    // toggle count clamped to the supported range
    always_comb begin
        momentary = (i_cfg.position_count < CW'(2));
        if (momentary) begin
            count = CW'(2);
        end else if (i_cfg.position_count > CW'(mpbc_pkg::MAX_POSITIONS)) begin
            count = CW'(mpbc_pkg::MAX_POSITIONS);
        end else begin
            count = i_cfg.position_count;
        end
    end

    // position update for an accepted transaction
    always_comb begin
        n_pos   = r_pos;
        n_prev  = r_prev;
        n_last  = r_last;
        pos_inc = {1'b0, r_pos} + CW'(1);
        elapsed = i_in_data.time_ms - r_last;
        rising  = i_in_data.pressed && !r_prev;
        if (i_in_data.req_type == mpbc_pkg::REQ_CLEAR) begin
            n_pos  = '0;
            n_prev = 1'b0;
        end else begin
            if (momentary) begin
                n_pos = PW'(i_in_data.pressed);
            end else if (rising) begin
                if (elapsed < TW'(i_cfg.double_press_ms)) begin
                    n_pos = '0;
                end else if (pos_inc >= count) begin
                    n_pos = '0;
                end else begin
                    n_pos = pos_inc[PW-1:0];
                end
                n_last = i_in_data.time_ms;
            end
            n_prev = i_in_data.pressed;
        end
    end

    // channel mapping
    always_comb begin
        direct = momentary || (count == CW'(2))
              || ((count == CW'(3)) && (r_pos == PW'(1)));
        if (momentary || (count == CW'(2))) begin
            direct_value = (r_pos != '0) ? i_cfg.channel_max : i_cfg.channel_min;
        end else begin
            direct_value = i_cfg.channel_mid;
        end
        span = {1'b0, i_cfg.channel_max} - {1'b0, i_cfg.channel_min};
        mag  = span[VW] ? VW'(-span) : span[VW-1:0];
        prod = QW'(mag) * QW'(r_pos);
    end

    // one restoring divide step
    always_comb begin
        trial = {r_rem, r_quo[QW-1]};
        q_bit = (trial >= {1'b0, r_div});
        if (q_bit) begin
            rem_next = PW'(trial - {1'b0, r_div});
        end else begin
            rem_next = trial[PW-1:0];
        end
    end

    assign o_status.direct = direct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= 1'b0;
            r_last <= '0;
        end else if (i_cmd.accept) begin
            r_pos  <= n_pos;
            r_prev <= n_prev;
            r_last <= n_last;
        end else if (i_cfg.pos_clear) begin
            r_pos <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_value <= direct_value;
            r_neg   <= span[VW];
            r_div   <= PW'(count - CW'(1));
            r_quo   <= prod;
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[QW-2:0], q_bit};
            r_rem <= rem_next;
        end
        if (i_cmd.div_finish) begin
            r_value <= r_neg ? (i_cfg.channel_min - r_quo[VW-1:0])
                             : (i_cfg.channel_min + r_quo[VW-1:0]);
        end
        if (i_cmd.out_load) begin
            r_out.position      <= r_pos;
            r_out.channel_value <= r_value;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

FILE: rtl/multi_position_button_channel.sv
// multi-position button channel: button samples in, position and channel value out
// top level; depends on mpbc_pkg, mpbc_regs, mpbc_ctrl and mpbc_dp
//
// input channel (i_in_valid / o_in_ready / i_in_data) carries one button
// sample with its millisecond timestamp, or a clear request. every input
// transaction yields exactly one output transaction (o_out_valid /
// i_out_ready / o_out_data) with the resulting position and channel value.
// registers are to be written by the user through the apb-style port only while
// the block is idle; the block itself does not enforce this. o_out_valid is
// registered from the output state, reached straight from the map state when the
// value is min, mid or max directly, and through the divide and finish states when
// the evenly spaced value needs the 16-step restoring divider; one item at a time.
// o_in_ready is high while the sequencer is idle, also while a finished
// result still waits in the output register; a stalled receiver holds the
// next result in the sequencer until the register frees.
// synchronous reset clears position, button history and registers to their
// defaults, and drops o_out_valid.
`default_nettype none

module multi_position_button_channel (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  mpbc_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output mpbc_pkg::t_out                       o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [mpbc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [mpbc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                                 pready
);

    mpbc_pkg::t_cfg    cfg;
    mpbc_pkg::t_cmd    cmd;
    mpbc_pkg::t_status status;

    mpbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mpbc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/mpbc_checker.sv
// port-level checker for the multi-position button channel, bound to the top
// depends on mpbc_pkg and multi_position_button_channel_assert.svh
`default_nettype none

`include "multi_position_button_channel_assert.svh"

module mpbc_checker (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input mpbc_pkg::t_out o_out_data
);

    `MPBC_ASSERT_NOW(a_reset_no_out, !$past(i_rst_n), !o_out_valid, "output valid right after reset")
    `MPBC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled output transaction changed")
    `MPBC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input ready right after an accepted transaction")
    `MPBC_ASSERT_NOW(a_ready_drop_on_accept, $fell(o_in_ready), $past(i_in_valid && o_in_ready), "input ready dropped without a transaction")

endmodule

bind multi_position_button_channel mpbc_checker u_mpbc_checker (.*);

`default_nettype wire

FILE: tb/multi_position_button_channel_tb.sv
// self-checking testbench for multi_position_button_channel
// drives button samples and clear requests, programs the apb registers and
// checks every output transaction; depends on mpbc_pkg and the rtl top level
`timescale 1ns / 100ps

module multi_position_button_channel_tb;
    import mpbc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_WAIT   = 25;

    class channel_tracker;
        logic [COUNT_WIDTH-1:0]  position_count;
        logic [WINDOW_WIDTH-1:0] window_ms;
        logic [VALUE_WIDTH-1:0]  value_min;
        logic [VALUE_WIDTH-1:0]  value_mid;
        logic [VALUE_WIDTH-1:0]  value_max;
        logic [POS_WIDTH-1:0]    position;
        logic                    prev_level;
        logic [TIME_WIDTH-1:0]   last_press_ms;
        t_out                    expected_q[$];
        int                      checked;
        int                      mismatches;

        function new();
            position_count = RST_POSITION_COUNT;
            window_ms      = RST_DOUBLE_PRESS;
            value_min      = RST_CHANNEL_MIN;
            value_mid      = RST_CHANNEL_MID;
            value_max      = RST_CHANNEL_MAX;
            position       = '0;
            prev_level     = 1'b0;
            last_press_ms  = '0;
            checked        = 0;
            mismatches     = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [DATA_WIDTH-1:0] value);
            case (idx)
                REG_POSITION_COUNT: begin
                    position_count = COUNT_WIDTH'(value);
                    position       = '0;
                end
                REG_DOUBLE_PRESS: window_ms = WINDOW_WIDTH'(value);
                REG_CHANNEL_MIN:  value_min = VALUE_WIDTH'(value);
                REG_CHANNEL_MID:  value_mid = VALUE_WIDTH'(value);
                REG_CHANNEL_MAX:  value_max = VALUE_WIDTH'(value);
                default: ;
            endcase
        endfunction

        function int positions();
            if (position_count < 2) return 2;
            if (position_count > MAX_POSITIONS) return MAX_POSITIONS;
            return int'(position_count);
        endfunction

        function logic [VALUE_WIDTH-1:0] channel_for(logic [POS_WIDTH-1:0] pos);
            int n;
            int span;
            int q;
            if (position_count <= 1) return (pos != 0) ? value_max : value_min;
            n = positions();
            if (n == 2) return (pos == 0) ? value_min : value_max;
            if (n == 3 && pos == 1) return value_mid;
            span = int'(value_max) - int'(value_min);
            q = (span * int'(pos)) / (n - 1);
            return VALUE_WIDTH'(int'(value_min) + q);
        endfunction

        function void note_sample(t_in item);
            logic [TIME_WIDTH-1:0] elapsed;
            t_out                  want;
            if (item.req_type == REQ_CLEAR) begin
                position   = '0;
                prev_level = 1'b0;
            end else begin
                if (position_count <= 1) begin
                    position = POS_WIDTH'(item.pressed);
                end else if (item.pressed && !prev_level) begin
                    elapsed = item.time_ms - last_press_ms;
                    if (elapsed < TIME_WIDTH'(window_ms))
                        position = '0;
                    else
                        position = POS_WIDTH'((int'(position) + 1) % positions());
                    last_press_ms = item.time_ms;
                end
                prev_level = item.pressed;
            end
            want.position      = position;
            want.channel_value = channel_for(position);
            expected_q.push_back(want);
        endfunction

        function void check_output(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected output transaction: position %0d value %0d",
                         $time, got.position, got.channel_value);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.position !== want.position) begin
                $display("%0t position mismatch: expected %0d actual %0d",
                         $time, want.position, got.position);
                mismatches++;
            end
            if (got.channel_value !== want.channel_value) begin
                $display("%0t channel value mismatch: expected %0d actual %0d",
                         $time, want.channel_value, got.channel_value);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    channel_tracker        tracker;
    int                    items_sent;
    int                    settings_count;
    int                    readback_errors;
    int                    holds_done;
    int                    cycle_count;
    int                    in_gap_max;
    int                    out_gap_max;
    bit                    long_hold_req;
    logic [TIME_WIDTH-1:0] press_ms;

    multi_position_button_channel uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t timeout with %0d results outstanding", $time, tracker.expected_q.size());
        $display("[multi_position_button_channel] ERROR");
        $finish;
    end

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(out_gap_max, 0);
            if (long_hold_req) begin
                stall = stall + LONG_HOLD;
                long_hold_req = 1'b0;
                holds_done++;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_output(o_out_data);
        end
    end

    task automatic send(input t_req req, input logic level, input logic [TIME_WIDTH-1:0] stamp);
        t_in item;
        int  gap;
        item.req_type = req;
        item.pressed  = level;
        item.time_ms  = stamp;
        gap = $urandom_range(in_gap_max, 0);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_sample(item);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value) begin
            $display("%0t register %s readback mismatch: expected %0d actual %0d",
                     $time, idx.name(), value, readback);
            readback_errors++;
        end
    endtask

    task automatic configure(input int count, input int window, input int vmin,
                             input int vmid, input int vmax);
        wait_idle();
        write_register(REG_POSITION_COUNT, DATA_WIDTH'(count));
        write_register(REG_DOUBLE_PRESS, DATA_WIDTH'(window));
        write_register(REG_CHANNEL_MIN, DATA_WIDTH'(vmin));
        write_register(REG_CHANNEL_MID, DATA_WIDTH'(vmid));
        write_register(REG_CHANNEL_MAX, DATA_WIDTH'(vmax));
        settings_count++;
    endtask

    function automatic int pick_level();
        case ($urandom_range(4, 0))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(4095, 0);
        endcase
    endfunction

    // mostly release/press pairs with the press spacing straddling the window
    task automatic run_random_phase(input int count);
        int                    stop;
        int                    r;
        logic [TIME_WIDTH-1:0] delta;
        stop = items_sent + count;
        while (items_sent < stop) begin
            r = $urandom_range(99, 0);
            if (r < 85) begin
                if (tracker.window_ms != 0 && $urandom_range(1, 0) == 1)
                    delta = $urandom_range(tracker.window_ms - 1, 0);
                else
                    delta = tracker.window_ms + $urandom_range(3000, 0);
                send(REQ_SAMPLE, 1'b0, press_ms + delta / 2);
                press_ms = press_ms + delta;
                send(REQ_SAMPLE, 1'b1, press_ms);
                if (r < 12) send(REQ_SAMPLE, 1'b1, press_ms + 1);
            end else begin
                send(($urandom_range(3, 0) == 0) ? REQ_CLEAR : REQ_SAMPLE,
                     1'($urandom_range(1, 0)), $urandom());
            end
        end
    endtask

    initial begin
        int count;
        int window;
        tracker         = new();
        items_sent      = 0;
        settings_count  = 0;
        readback_errors = 0;
        holds_done      = 0;
        in_gap_max      = 0;
        out_gap_max     = 0;
        long_hold_req   = 1'b0;
        press_ms        = '0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_out_ready     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: momentary mode
        in_gap_max  = 3;
        out_gap_max = 3;
        send(REQ_SAMPLE, 1'b1, 32'd5);
        send(REQ_SAMPLE, 1'b0, 32'd9);

        // four positions, first press early against a zero press time
        wait_idle();
        write_register(REG_POSITION_COUNT, 32'd4);
        send(REQ_SAMPLE, 1'b1, 32'd100);
        send(REQ_SAMPLE, 1'b0, 32'd150);
        send(REQ_SAMPLE, 1'b1, 32'd500);
        send(REQ_SAMPLE, 1'b1, 32'd600);
        send(REQ_SAMPLE, 1'b0, 32'd650);
        send(REQ_SAMPLE, 1'b1, 32'd700);
        send(REQ_SAMPLE, 1'b0, 32'd800);
        send(REQ_SAMPLE, 1'b1, 32'd1100);
        send(REQ_SAMPLE, 1'b0, 32'd1200);
        send(REQ_SAMPLE, 1'b1, 32'd1500);
        send(REQ_CLEAR, 1'b1, $urandom());
        send(REQ_SAMPLE, 1'b1, 32'd1700);

        // three positions, falling ramp, timestamp wrap
        configure(3, 64, 4095, 2048, 0);
        send(REQ_SAMPLE, 1'b1, 32'hFFFF_FF00);
        send(REQ_SAMPLE, 1'b0, 32'hFFFF_FF20);
        send(REQ_SAMPLE, 1'b1, 32'hFFFF_FF40);
        send(REQ_SAMPLE, 1'b0, 32'hFFFF_FFF0);
        send(REQ_SAMPLE, 1'b1, 32'h0000_0010);
        send(REQ_SAMPLE, 1'b0, 32'h0000_0018);
        send(REQ_SAMPLE, 1'b1, 32'h0000_0020);

        // count above range, widest window
        configure(31, 65535, 0, 4095, 4095);
        send(REQ_SAMPLE, 1'b0, 32'h0002_0000);
        send(REQ_SAMPLE, 1'b1, 32'h0003_0000);
        send(REQ_SAMPLE, 1'b0, 32'h0003_0008);
        send(REQ_SAMPLE, 1'b1, 32'h0003_0010);

        for (int p = 0; p < 14; p++) begin
            case (p)
                0:       count = 0;
                1:       count = 16;
                2:       count = 2;
                3:       count = 1;
                default: begin
                    case ($urandom_range(9, 0))
                        0:       count = $urandom_range(1, 0);
                        1:       count = 16;
                        2:       count = $urandom_range(31, 17);
                        3:       count = 3;
                        default: count = $urandom_range(16, 2);
                    endcase
                end
            endcase
            case (p)
                4:       window = 0;
                5:       window = 65535;
                default: window = $urandom_range(1000, 0);
            endcase
            configure(count, window, pick_level(), pick_level(), pick_level());
            press_ms    = ($urandom_range(3, 0) == 0) ? 32'hFFFF_F000 : $urandom();
            in_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 18;
            out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 18;
            if (p == 2 || p == 9) begin
                in_gap_max    = 0;
                long_hold_req = 1'b1;
            end
            run_random_phase(50);
        end

        wait_idle();
        if (tracker.expected_q.size() != 0)
            $display("%0t %0d expected results never arrived", $time, tracker.expected_q.size());
        $display("checked %0d results from %0d input transactions over %0d register settings",
                 tracker.checked, items_sent, settings_count);
        $display("receiver hold-offs: %0d, register readback errors: %0d",
                 holds_done, readback_errors);
        if (tracker.mismatches == 0 && readback_errors == 0 && tracker.expected_q.size() == 0) begin
            $display("[multi_position_button_channel] OK");
        end else begin
            $display("[multi_position_button_channel] ERROR");
        end
        $finish;
    end

endmodule
